FILE: hdl/bfmp_pkg.sv
`timescale 1ns / 1ps

package bfmp_pkg;

   localparam int MAX_CITIES  = 8;
   localparam int WEIGHT_BITS = 16;

   localparam int CITY_BITS   = $clog2(MAX_CITIES);
   localparam int CNT_BITS    = $clog2(MAX_CITIES + 1);
   localparam int DIST_DEPTH  = MAX_CITIES * MAX_CITIES;
   localparam int ADDR_BITS   = $clog2(DIST_DEPTH);

   localparam int COST_BITS   = 20;
   localparam int COUNT_BITS  = 16;
   localparam int ACC_BITS    = ((COST_BITS > WEIGHT_BITS) ? COST_BITS : WEIGHT_BITS) + 1;

   localparam logic [COST_BITS-1:0]  COST_MAX  = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      KIND_EDGE   = 1'b0,
      KIND_SEARCH = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  city_a;
      logic [2:0]  city_b;
      logic [15:0] weight;
   } req_type;

   typedef struct packed {
      logic [COST_BITS-1:0]  min_cost;
      logic [COUNT_BITS-1:0] perm_count;
   } rsp_type;

   // Classified work item as held in the queue
   typedef struct packed {
      kind_type               kind;
      logic [CITY_BITS-1:0]   city_a;
      logic [CITY_BITS-1:0]   city_b;
      logic [WEIGHT_BITS-1:0] weight;
   } entry_type;

   // Handshake between queue and engine
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_out_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_FIND,
      ST_PERMUTE,
      ST_EMIT
   } state_type;

endpackage

FILE: hdl/bfmp_front.sv
`timescale 1ns / 1ps

module bfmp_front import bfmp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output queue_out_type q_out,
   input  logic          q_pop
);

   entry_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  accept;
   logic                  drop;
   logic                  push;
   logic                  pop;
   entry_type             new_entry;

   assign req_stall = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Edges naming a city past the table are dropped at the door
   assign drop = (req_data.kind == KIND_EDGE) &&
                 ((int'(req_data.city_a) >= MAX_CITIES) ||
                  (int'(req_data.city_b) >= MAX_CITIES));

   assign push = accept && !drop;
   assign pop  = q_pop && (count_ff != '0);

   always_comb begin
      new_entry.kind   = req_data.kind;
      new_entry.city_a = CITY_BITS'(req_data.city_a);
      new_entry.city_b = CITY_BITS'(req_data.city_b);
      new_entry.weight = WEIGHT_BITS'(req_data.weight);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.entry = slot_ff[rd_ptr_ff];

endmodule

FILE: hdl/bfmp_engine.sv
`timescale 1ns / 1ps

module bfmp_engine import bfmp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type q_out,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   state_type state_ff, state_in;

   logic [WEIGHT_BITS-1:0] dist_mem [DIST_DEPTH];
   logic [DIST_DEPTH-1:0]  dist_vld_ff;
   logic [WEIGHT_BITS-1:0] rd_data_ff;
   logic                   rd_hit_ff;
   logic                   rd_pend_ff;

   logic [MAX_CITIES-1:0]  seen_ff;
   logic [CITY_BITS-1:0]   order_ff [MAX_CITIES];
   logic [CITY_BITS-1:0]   order_in [MAX_CITIES];
   logic [CNT_BITS-1:0]    k_ff, k_in;
   logic [CNT_BITS-1:0]    iss_ff, iss_in;
   logic [CITY_BITS-1:0]   piv_ff;
   logic [COST_BITS-1:0]   sum_ff, sum_in;
   logic [COST_BITS-1:0]   best_ff, best_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   out_vld_ff, out_vld_in;
   rsp_type                out_data_ff;

   logic                   edge_wr;
   logic                   load_en;
   logic                   sum_en;
   logic                   find_en;
   logic                   perm_en;
   logic                   emit_en;
   logic                   out_free;

   logic [ADDR_BITS-1:0]   wr_addr;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [CNT_BITS-1:0]    iss_nx;
   logic                   issue;
   logic                   sum_done;
   logic [WEIGHT_BITS-1:0] rd_word;
   logic [ACC_BITS-1:0]    acc;

   logic [CITY_BITS-1:0]   load_order [MAX_CITIES];
   logic [CNT_BITS-1:0]    load_k;
   logic                   has_next;
   logic [CITY_BITS-1:0]   piv;
   logic [CITY_BITS-1:0]   perm_order [MAX_CITIES];

   // ---------------- control ----------------
   assign out_free = !out_vld_ff || !rsp_stall;
   assign iss_nx   = iss_ff + CNT_BITS'(1);
   assign issue    = (state_ff == ST_SUM) && (iss_nx < k_ff);
   assign sum_done = (state_ff == ST_SUM) && !issue && !rd_pend_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_out.valid && q_out.entry.kind == KIND_SEARCH) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum_done) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            state_in = has_next ? ST_PERMUTE : ST_EMIT;
         end
         ST_PERMUTE: begin
            state_in = ST_SUM;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop   = 1'b0;
      load_en = 1'b0;
      sum_en  = 1'b0;
      find_en = 1'b0;
      perm_en = 1'b0;
      emit_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop = q_out.valid;
         end
         ST_LOAD: begin
            load_en = 1'b1;
         end
         ST_SUM: begin
            sum_en = 1'b1;
         end
         ST_FIND: begin
            find_en = 1'b1;
         end
         ST_PERMUTE: begin
            perm_en = 1'b1;
         end
         ST_EMIT: begin
            emit_en = out_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   assign edge_wr = q_pop && (q_out.entry.kind == KIND_EDGE);

   // ---------------- distance store ----------------
   // One entry per unordered pair, kept at (low city, high city)
   always_comb begin
      logic [CITY_BITS-1:0] wa;
      logic [CITY_BITS-1:0] wb;
      logic [CITY_BITS-1:0] ra;
      logic [CITY_BITS-1:0] rb;
      wa = q_out.entry.city_a;
      wb = q_out.entry.city_b;
      if (wa > wb) begin
         wa = q_out.entry.city_b;
         wb = q_out.entry.city_a;
      end
      wr_addr = ADDR_BITS'(int'(wa) * MAX_CITIES + int'(wb));
      ra = order_ff[iss_ff[CITY_BITS-1:0]];
      rb = order_ff[iss_nx[CITY_BITS-1:0]];
      if (ra > rb) begin
         ra = order_ff[iss_nx[CITY_BITS-1:0]];
         rb = order_ff[iss_ff[CITY_BITS-1:0]];
      end
      rd_addr = ADDR_BITS'(int'(ra) * MAX_CITIES + int'(rb));
   end

   always_ff @(posedge clock) begin
      if (edge_wr) begin
         dist_mem[wr_addr] <= q_out.entry.weight;
      end
      if (issue) begin
         rd_data_ff <= dist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_vld_ff <= '0;
         seen_ff     <= '0;
         rd_hit_ff   <= 1'b0;
      end else begin
         if (edge_wr) begin
            dist_vld_ff[wr_addr]         <= 1'b1;
            seen_ff[q_out.entry.city_a]  <= 1'b1;
            seen_ff[q_out.entry.city_b]  <= 1'b1;
         end
         if (issue) begin
            rd_hit_ff <= dist_vld_ff[rd_addr];
         end
      end
   end

   // A pair never written reads as zero
   assign rd_word = rd_hit_ff ? rd_data_ff : '0;
   assign acc     = ACC_BITS'(sum_ff) + ACC_BITS'(rd_word);

   // ---------------- city list ----------------
   always_comb begin
      logic [CNT_BITS-1:0] rank;
      rank = '0;
      for (int p = 0; p < MAX_CITIES; p++) begin
         load_order[p] = order_ff[p];
      end
      for (int c = 0; c < MAX_CITIES; c++) begin
         if (seen_ff[c]) begin
            load_order[rank[CITY_BITS-1:0]] = CITY_BITS'(c);
            rank = rank + CNT_BITS'(1);
         end
      end
      load_k = rank;
   end

   // ---------------- next permutation ----------------
   // Pivot: rightmost rise in the active list
   always_comb begin
      has_next = 1'b0;
      piv      = '0;
      for (int p = 1; p < MAX_CITIES; p++) begin
         if (CNT_BITS'(p) < k_ff && order_ff[p-1] < order_ff[p]) begin
            has_next = 1'b1;
            piv      = CITY_BITS'(p);
         end
      end
   end

   // Swap the pivot with its rightmost larger successor, then reverse the tail
   always_comb begin
      logic [CITY_BITS-1:0] pv;
      logic [CITY_BITS-1:0] pm1;
      logic [CITY_BITS-1:0] succ;
      logic [CNT_BITS-1:0]  mirror;
      logic [CITY_BITS-1:0] sw [MAX_CITIES];
      pm1  = piv_ff - CITY_BITS'(1);
      pv   = order_ff[pm1];
      succ = '0;
      for (int j = 0; j < MAX_CITIES; j++) begin
         if (CNT_BITS'(j) < k_ff && order_ff[j] > pv) begin
            succ = CITY_BITS'(j);
         end
      end
      for (int p = 0; p < MAX_CITIES; p++) begin
         sw[p] = order_ff[p];
      end
      sw[pm1]  = order_ff[succ];
      sw[succ] = pv;
      for (int p = 0; p < MAX_CITIES; p++) begin
         mirror = CNT_BITS'(piv_ff) + k_ff - CNT_BITS'(1) - CNT_BITS'(p);
         if (CITY_BITS'(p) >= piv_ff && CNT_BITS'(p) < k_ff) begin
            perm_order[p] = sw[mirror[CITY_BITS-1:0]];
         end else begin
            perm_order[p] = sw[p];
         end
      end
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      for (int p = 0; p < MAX_CITIES; p++) begin
         order_in[p] = order_ff[p];
      end
      k_in     = k_ff;
      iss_in   = iss_ff;
      sum_in   = sum_ff;
      best_in  = best_ff;
      count_in = count_ff;
      if (load_en) begin
         for (int p = 0; p < MAX_CITIES; p++) begin
            order_in[p] = load_order[p];
         end
         k_in     = load_k;
         iss_in   = '0;
         sum_in   = '0;
         best_in  = COST_MAX;
         count_in = '0;
      end
      if (sum_en) begin
         if (issue) begin
            iss_in = iss_nx;
         end
         if (rd_pend_ff) begin
            sum_in = (acc > ACC_BITS'(COST_MAX)) ? COST_MAX : acc[COST_BITS-1:0];
         end
         if (sum_done) begin
            best_in  = (sum_ff < best_ff) ? sum_ff : best_ff;
            count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_BITS'(1);
         end
      end
      if (perm_en) begin
         for (int p = 0; p < MAX_CITIES; p++) begin
            order_in[p] = perm_order[p];
         end
         iss_in = '0;
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < MAX_CITIES; p++) begin
         order_ff[p] <= order_in[p];
      end
      k_ff     <= k_in;
      iss_ff   <= iss_in;
      sum_ff   <= sum_in;
      best_ff  <= best_in;
      count_ff <= count_in;
      if (find_en) begin
         piv_ff <= piv;
      end
      if (emit_en) begin
         out_data_ff.min_cost   <= best_ff;
         out_data_ff.perm_count <= count_ff;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      out_vld_in = out_vld_ff;
      if (emit_en) begin
         out_vld_in = 1'b1;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= issue;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: hdl/brute_force_min_path_search.sv
// Order: an edge beat is queued on acceptance and written to the store when the idle
// engine pops it. A search beat walks each order of the seen cities with a store read per
// leg, then drain, compare, pivot and reorder steps (the last order skips the reorder).
// Throughput: one edge beat per cycle while the engine is idle; the single-port distance
// store sets the walk rate. Reset (synchronous, active high) clears the store valid bits,
// seen map, queue and result register valid flag.
`timescale 1ns / 1ps

module brute_force_min_path_search import bfmp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Front side: accept beats, drop out-of-range edges, queue the rest
   queue_out_type q_out;
   logic          q_pop;

   bfmp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_out     (q_out),
      .q_pop     (q_pop)
   );

   // Back side: write edges, or walk every ordering of the seen cities
   // and hold the best open-path cost and order count in the result register
   bfmp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/brute_force_min_path_search_tb.sv
`timescale 1ns / 1ps

module brute_force_min_path_search_tb import bfmp_pkg::*; ();

   // Run length guard: a run that has not finished by the limit is aborted.
   localparam int unsigned CYCLE_LIMIT    = 10_000_000;
   localparam int unsigned HOLDOFF_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES   = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   brute_force_min_path_search u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Model of the block: distance store, seen map, pending search results
   logic [WEIGHT_BITS-1:0] dist_model [MAX_CITIES][MAX_CITIES];
   logic [MAX_CITIES-1:0]  seen_model;
   rsp_type                search_result_q [$];

   // Cities in the order the stimulus brings them into play
   logic [2:0] city_seq [MAX_CITIES];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Idle control: quiet means no gaps on that side
   bit          send_quiet = 1'b0;
   bit          sink_quiet = 1'b0;
   int unsigned sink_wait = 0;
   int unsigned sink_draw;
   int unsigned holdoff_ask = 0;
   int unsigned holdoff_served = 0;
   int unsigned holdoff_left = 0;
   rsp_type     want;

   initial begin
      forever #10 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[brute_force_min_path_search] ERROR");
         $finish;
      end
   end

   function automatic int unsigned draw_wait(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   // Favor the weight extremes, otherwise any value
   function automatic logic [15:0] pick_weight();
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return 16'h0000;
      if (sel == 1) return 16'hFFFF;
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic req_type make_edge(input logic [2:0] a, input logic [2:0] b,
                                         input logic [15:0] w);
      req_type r;
      r.kind   = KIND_EDGE;
      r.city_a = a;
      r.city_b = b;
      r.weight = w;
      return r;
   endfunction

   // Search beat: the city and weight fields carry random junk that must be ignored
   function automatic req_type make_search();
      req_type r;
      r.kind   = KIND_SEARCH;
      r.city_a = 3'($urandom_range(0, 7));
      r.city_b = 3'($urandom_range(0, 7));
      r.weight = 16'($urandom_range(0, 16'hFFFF));
      return r;
   endfunction

   // Edge between two of the first n cities in play, sometimes a self edge
   function automatic req_type rand_edge(input int unsigned n);
      logic [2:0] a;
      logic [2:0] b;
      a = city_seq[$urandom_range(0, n - 1)];
      b = ($urandom_range(0, 7) == 0) ? a : city_seq[$urandom_range(0, n - 1)];
      return make_edge(a, b, pick_weight());
   endfunction

   // Walk every order of the seen cities, lexicographic from ascending, and keep
   // the cheapest open path (no return leg) and the number of orders walked.
   function automatic rsp_type search_min_path();
      logic [2:0]            ord [MAX_CITIES];
      logic [2:0]            t;
      logic [COST_BITS-1:0]  best;
      logic [COUNT_BITS-1:0] cnt;
      int unsigned           sum;
      int                    k;
      int                    i;
      int                    j;
      bit                    more;
      rsp_type               r;
      k = 0;
      for (int c = 0; c < MAX_CITIES; c++) begin
         if (seen_model[c]) begin
            ord[k] = 3'(c);
            k++;
         end
      end
      best = COST_MAX;
      cnt  = '0;
      more = 1'b1;
      while (more) begin
         if (cnt != COUNT_MAX) cnt++;
         sum = 0;
         for (i = 0; i + 1 < k; i++) begin
            sum = sum + dist_model[ord[i]][ord[i + 1]];
            if (sum > COST_MAX) sum = COST_MAX;
         end
         if (sum < best) best = sum[COST_BITS-1:0];
         // Step to the next order; stop after the descending one
         more = 1'b0;
         if (k >= 2) begin
            i = k - 1;
            while (i > 0 && ord[i - 1] >= ord[i]) i--;
            if (i > 0) begin
               j = k - 1;
               while (ord[j] <= ord[i - 1]) j--;
               t          = ord[i - 1];
               ord[i - 1] = ord[j];
               ord[j]     = t;
               j = k - 1;
               while (i < j) begin
                  t      = ord[i];
                  ord[i] = ord[j];
                  ord[j] = t;
                  i++;
                  j--;
               end
               more = 1'b1;
            end
         end
      end
      r.min_cost   = best;
      r.perm_count = cnt;
      return r;
   endfunction

   // Offer one beat after a random gap and hold it until taken. Valid stays
   // high when the next beat follows without a gap.
   task automatic send_beat(input req_type item);
      int unsigned gap;
      gap = draw_wait(send_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      // Taken at this edge: advance the model
      if (item.kind == KIND_EDGE) begin
         if (item.city_a < MAX_CITIES && item.city_b < MAX_CITIES) begin
            dist_model[item.city_a][item.city_b] = item.weight[WEIGHT_BITS-1:0];
            dist_model[item.city_b][item.city_a] = item.weight[WEIGHT_BITS-1:0];
            seen_model[item.city_a] = 1'b1;
            seen_model[item.city_b] = 1'b1;
         end
      end else begin
         search_result_q.push_back(search_min_path());
      end
   endtask

   // Receiver: a long hold-off on request, else a random wait after each beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall      <= 1'b0;
         sink_wait      <= 0;
         holdoff_left   <= 0;
         holdoff_served <= 0;
      end else if (holdoff_served != holdoff_ask) begin
         holdoff_served <= holdoff_ask;
         holdoff_left   <= HOLDOFF_CYCLES;
         rsp_stall      <= 1'b1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_stall    <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         sink_draw = draw_wait(sink_quiet);
         sink_wait <= sink_draw;
         rsp_stall <= (sink_draw != 0);
      end else if (sink_wait > 1) begin
         sink_wait <= sink_wait - 1;
         rsp_stall <= 1'b1;
      end else begin
         sink_wait <= 0;
         rsp_stall <= 1'b0;
      end
   end

   // Check each result beat against the oldest pending search
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (search_result_q.size() == 0) begin
            $error("result beat with no search pending: min_cost %0d perm_count %0d",
                   rsp_data.min_cost, rsp_data.perm_count);
            error_count++;
         end else begin
            want = search_result_q.pop_front();
            if (rsp_data.min_cost !== want.min_cost) begin
               $error("min_cost: expected %0d, got %0d", want.min_cost, rsp_data.min_cost);
               error_count++;
            end
            if (rsp_data.perm_count !== want.perm_count) begin
               $error("perm_count: expected %0d, got %0d",
                      want.perm_count, rsp_data.perm_count);
               error_count++;
            end
         end
      end
   end

   // Nothing seen yet: one empty order, zero cost
   task automatic test_empty_map();
      send_beat(make_search());
   endtask

   // Diagonal entry is written but no path reads it
   task automatic test_self_edge();
      send_beat(make_edge(city_seq[0], city_seq[0], 16'hFFFF));
      send_beat(make_search());
   endtask

   // Two cities, then overwrite the pair from the other side
   task automatic test_two_cities();
      send_beat(make_edge(city_seq[0], city_seq[1], 16'hFFFF));
      send_beat(make_search());
      send_beat(make_edge(city_seq[1], city_seq[0], 16'd5));
      send_beat(make_search());
   endtask

   // Third city with no loaded pairs; search twice to show the store persists
   task automatic test_unset_pairs();
      send_beat(make_edge(city_seq[2], city_seq[2], 16'd1234));
      send_beat(make_search());
      send_beat(make_search());
   endtask

   task automatic test_weight_extremes();
      send_beat(make_edge(city_seq[0], city_seq[2], 16'hFFFF));
      send_beat(make_edge(city_seq[1], city_seq[2], 16'hFFFF));
      send_beat(make_edge(city_seq[0], city_seq[1], 16'h0000));
      send_beat(make_search());
   endtask

   // Hold the receiver off for a long stretch while beats keep coming, so the
   // block backs up and stalls its input
   task automatic test_output_holdoff();
      send_quiet = 1'b1;
      holdoff_ask <= holdoff_ask + 1;
      send_beat(make_search());
      for (int i = 0; i < 4; i++) send_beat(rand_edge(3));
      send_beat(make_search());
      send_beat(make_search());
      for (int i = 0; i < 4; i++) send_beat(rand_edge(3));
      send_beat(make_search());
      send_quiet = 1'b0;
   endtask

   // Grow the set of cities in play; searches get rarer as they get costlier
   task automatic test_random_growth();
      int unsigned count;
      int unsigned ratio;
      bit          hit;
      for (int n = 3; n <= 7; n++) begin
         case (n)
            3: begin
               count = 300;
               ratio = 6;
            end
            4: begin
               count = 300;
               ratio = 6;
            end
            5: begin
               count = 300;
               ratio = 8;
            end
            6: begin
               count = 250;
               ratio = 12;
            end
            default: begin
               count = 150;
               ratio = 50;
            end
         endcase
         for (int i = 0; i < count; i++) begin
            // Switch idling on and off in stretches
            if (i % 50 == 0) begin
               send_quiet = ($urandom_range(0, 3) == 0);
               sink_quiet = ($urandom_range(0, 3) == 0);
            end
            if (n >= 7) hit = (i % ratio == ratio - 1);
            else hit = ($urandom_range(0, ratio - 1) == 0);
            send_beat(hit ? make_search() : rand_edge(n));
         end
      end
      send_quiet = 1'b0;
      sink_quiet = 1'b0;
   endtask

   // All eight cities, every pair loaded from both orders of the endpoints
   task automatic test_full_map();
      for (int a = 0; a < MAX_CITIES; a++) begin
         for (int b = 0; b < MAX_CITIES; b++) begin
            if (a != b) send_beat(make_edge(3'(a), 3'(b), pick_weight()));
         end
      end
      send_beat(make_edge(3'd7, 3'd7, 16'hFFFF));
      send_beat(make_search());
   endtask

   initial begin
      for (int c = 0; c < MAX_CITIES; c++) begin
         seen_model[c] = 1'b0;
         city_seq[c]   = 3'(c);
         for (int d = 0; d < MAX_CITIES; d++) dist_model[c][d] = '0;
      end
      // Shuffle the order in which cities come into play
      for (int c = MAX_CITIES - 1; c > 0; c--) begin
         automatic int   j = $urandom_range(0, c);
         automatic logic [2:0] t = city_seq[c];
         city_seq[c] = city_seq[j];
         city_seq[j] = t;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_map();
      test_self_edge();
      test_two_cities();
      test_unset_pairs();
      test_weight_extremes();
      test_output_holdoff();
      test_random_growth();
      test_full_map();

      // Drop valid, wait out every pending search, then let stray beats show up
      req_valid <= 1'b0;
      while (search_result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[brute_force_min_path_search] OK");
      end else begin
         $display("[brute_force_min_path_search] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/bfmp_pkg.sv
hdl/bfmp_front.sv
hdl/bfmp_engine.sv
hdl/brute_force_min_path_search.sv
verif/brute_force_min_path_search_tb.sv
